// ===== src/angular_grid_ray_generator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared check macros for the ray generator; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ANGULAR_GRID_RAY_GENERATOR_UNIT_DEFINES_SVH
`define ANGULAR_GRID_RAY_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AGRG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// next-cycle implication
`define AGRG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define AGRG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AGRG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/agrg_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray generator package
// Widths, fixed-point constants, microcode program and shared types.
// ----------------------------------------------------------------------------
package agrg_pkg;

	// field widths
	localparam int AP_W       = 16;
	localparam int CFG_CNT_W  = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ANG_W      = 18;
	localparam int COMP_W     = 16;
	localparam int IDX_OUT_W  = 10;
	localparam int TRIG_W     = 32;
	localparam int CX_W       = 34;
	localparam int CZ_W       = 36;
	localparam int ITER_W     = 5;
	localparam int DIV_STEPS  = 16;

	localparam int MAX_POINTS_DEF   = 1024;
	localparam int CORDIC_STEPS_DEF = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_H_APERTURE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_V_APERTURE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_H_COUNT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_V_COUNT    = 3'd3;

	localparam logic [AP_W-1:0]      H_APERTURE_RST = 16'd8192;
	localparam logic [AP_W-1:0]      V_APERTURE_RST = 16'd8192;
	localparam logic [CFG_CNT_W-1:0] H_COUNT_RST    = 11'd1;
	localparam logic [CFG_CNT_W-1:0] V_COUNT_RST    = 11'd1;

	// Q2.30 constants
	localparam logic signed [CZ_W-1:0] TWO_PI_Q30   = 36'sd6746518852;
	localparam logic signed [CZ_W-1:0] PI_Q30       = 36'sd3373259426;
	localparam logic signed [CZ_W-1:0] NEG_PI_Q30   = -36'sd3373259426;
	localparam logic signed [CZ_W-1:0] HALF_PI_Q30  = 36'sd1686629713;
	localparam logic signed [CZ_W-1:0] NEG_HALF_PI  = -36'sd1686629713;
	localparam logic signed [CX_W-1:0] CORDIC_GAIN  = 34'sd652032874;

	// micro-operations
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT     = 5'd1;
	localparam logic [OP_W-1:0] OP_DIVH_INIT  = 5'd2;
	localparam logic [OP_W-1:0] OP_DIV_STEP   = 5'd3;
	localparam logic [OP_W-1:0] OP_DIVH_STORE = 5'd4;
	localparam logic [OP_W-1:0] OP_DIVV_STORE = 5'd5;
	localparam logic [OP_W-1:0] OP_LOAD_ZH    = 5'd6;
	localparam logic [OP_W-1:0] OP_LOAD_ZV    = 5'd7;
	localparam logic [OP_W-1:0] OP_RED_SUB    = 5'd8;
	localparam logic [OP_W-1:0] OP_RED_ADD    = 5'd9;
	localparam logic [OP_W-1:0] OP_FOLD       = 5'd10;
	localparam logic [OP_W-1:0] OP_CORDIC     = 5'd11;
	localparam logic [OP_W-1:0] OP_STORE_H    = 5'd12;
	localparam logic [OP_W-1:0] OP_STORE_V    = 5'd13;
	localparam logic [OP_W-1:0] OP_MUL_X      = 5'd14;
	localparam logic [OP_W-1:0] OP_MUL_Z      = 5'd15;
	localparam logic [OP_W-1:0] OP_EMIT       = 5'd16;

	// jump conditions
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_NEVER      = 3'd0;
	localparam logic [COND_W-1:0] C_ALWAYS     = 3'd1;
	localparam logic [COND_W-1:0] C_NO_REQ     = 3'd2;
	localparam logic [COND_W-1:0] C_NO_RESTART = 3'd3;
	localparam logic [COND_W-1:0] C_ITER_BUSY  = 3'd4;
	localparam logic [COND_W-1:0] C_Z_GT_PI    = 3'd5;
	localparam logic [COND_W-1:0] C_Z_LE_NPI   = 3'd6;
	localparam logic [COND_W-1:0] C_OUT_FULL   = 3'd7;

	// program addresses
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] PC_WAIT      = 5'd0;
	localparam logic [PC_W-1:0] PC_CHK_RST   = 5'd1;
	localparam logic [PC_W-1:0] PC_DIVH_INIT = 5'd2;
	localparam logic [PC_W-1:0] PC_DIVH_LOOP = 5'd3;
	localparam logic [PC_W-1:0] PC_DIVH_ST   = 5'd4;
	localparam logic [PC_W-1:0] PC_DIVV_LOOP = 5'd5;
	localparam logic [PC_W-1:0] PC_DIVV_ST   = 5'd6;
	localparam logic [PC_W-1:0] PC_H_LOAD    = 5'd7;
	localparam logic [PC_W-1:0] PC_H_SUB     = 5'd8;
	localparam logic [PC_W-1:0] PC_H_ADD     = 5'd9;
	localparam logic [PC_W-1:0] PC_H_FOLD    = 5'd10;
	localparam logic [PC_W-1:0] PC_H_ROT     = 5'd11;
	localparam logic [PC_W-1:0] PC_H_STORE   = 5'd12;
	localparam logic [PC_W-1:0] PC_V_LOAD    = 5'd13;
	localparam logic [PC_W-1:0] PC_V_SUB     = 5'd14;
	localparam logic [PC_W-1:0] PC_V_ADD     = 5'd15;
	localparam logic [PC_W-1:0] PC_V_FOLD    = 5'd16;
	localparam logic [PC_W-1:0] PC_V_ROT     = 5'd17;
	localparam logic [PC_W-1:0] PC_V_STORE   = 5'd18;
	localparam logic [PC_W-1:0] PC_MUL_X     = 5'd19;
	localparam logic [PC_W-1:0] PC_MUL_Z     = 5'd20;
	localparam logic [PC_W-1:0] PC_EMIT      = 5'd21;
	localparam logic [PC_W-1:0] PC_BACK      = 5'd22;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} uword_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ITER_W-1:0] iter;
	} ctrl_t;

	typedef struct packed {
		logic req_valid;
		logic restart;
		logic out_full;
		logic z_gt_pi;
		logic z_le_npi;
	} status_t;

	// control store
	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			PC_WAIT:      w = '{OP_ACCEPT,     C_NO_REQ,     PC_WAIT};
			PC_CHK_RST:   w = '{OP_NOP,        C_NO_RESTART, PC_H_LOAD};
			PC_DIVH_INIT: w = '{OP_DIVH_INIT,  C_NEVER,      PC_WAIT};
			PC_DIVH_LOOP: w = '{OP_DIV_STEP,   C_ITER_BUSY,  PC_DIVH_LOOP};
			PC_DIVH_ST:   w = '{OP_DIVH_STORE, C_NEVER,      PC_WAIT};
			PC_DIVV_LOOP: w = '{OP_DIV_STEP,   C_ITER_BUSY,  PC_DIVV_LOOP};
			PC_DIVV_ST:   w = '{OP_DIVV_STORE, C_NEVER,      PC_WAIT};
			PC_H_LOAD:    w = '{OP_LOAD_ZH,    C_NEVER,      PC_WAIT};
			PC_H_SUB:     w = '{OP_RED_SUB,    C_Z_GT_PI,    PC_H_SUB};
			PC_H_ADD:     w = '{OP_RED_ADD,    C_Z_LE_NPI,   PC_H_ADD};
			PC_H_FOLD:    w = '{OP_FOLD,       C_NEVER,      PC_WAIT};
			PC_H_ROT:     w = '{OP_CORDIC,     C_ITER_BUSY,  PC_H_ROT};
			PC_H_STORE:   w = '{OP_STORE_H,    C_NEVER,      PC_WAIT};
			PC_V_LOAD:    w = '{OP_LOAD_ZV,    C_NEVER,      PC_WAIT};
			PC_V_SUB:     w = '{OP_RED_SUB,    C_Z_GT_PI,    PC_V_SUB};
			PC_V_ADD:     w = '{OP_RED_ADD,    C_Z_LE_NPI,   PC_V_ADD};
			PC_V_FOLD:    w = '{OP_FOLD,       C_NEVER,      PC_WAIT};
			PC_V_ROT:     w = '{OP_CORDIC,     C_ITER_BUSY,  PC_V_ROT};
			PC_V_STORE:   w = '{OP_STORE_V,    C_NEVER,      PC_WAIT};
			PC_MUL_X:     w = '{OP_MUL_X,      C_NEVER,      PC_WAIT};
			PC_MUL_Z:     w = '{OP_MUL_Z,      C_NEVER,      PC_WAIT};
			PC_EMIT:      w = '{OP_EMIT,       C_OUT_FULL,   PC_EMIT};
			PC_BACK:      w = '{OP_NOP,        C_ALWAYS,     PC_WAIT};
			default:      w = '{OP_NOP,        C_ALWAYS,     PC_WAIT};
		endcase
		return w;
	endfunction

	// atan(2^-i) in Q2.30
	function automatic logic [TRIG_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
		logic [TRIG_W-1:0] a;
		case (i)
			5'd0:    a = 32'd843314857;
			5'd1:    a = 32'd497837829;
			5'd2:    a = 32'd263043837;
			5'd3:    a = 32'd133525159;
			5'd4:    a = 32'd67021687;
			5'd5:    a = 32'd33543516;
			5'd6:    a = 32'd16775851;
			5'd7:    a = 32'd8388437;
			5'd8:    a = 32'd4194283;
			5'd9:    a = 32'd2097149;
			5'd10:   a = 32'd1048576;
			5'd11:   a = 32'd524288;
			5'd12:   a = 32'd262144;
			5'd13:   a = 32'd131072;
			5'd14:   a = 32'd65536;
			5'd15:   a = 32'd32768;
			5'd16:   a = 32'd16384;
			5'd17:   a = 32'd8192;
			5'd18:   a = 32'd4096;
			5'd19:   a = 32'd2048;
			5'd20:   a = 32'd1024;
			5'd21:   a = 32'd512;
			5'd22:   a = 32'd256;
			5'd23:   a = 32'd128;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== src/agrg_ifs.sv =====
// ----------------------------------------------------------------------------
// Ray generator channels
// Request and ray channels, valid/ready with payload.
// ----------------------------------------------------------------------------
interface agrg_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface agrg_ray_if import agrg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [COMP_W-1:0] ray_x;
	logic signed [COMP_W-1:0] ray_y;
	logic signed [COMP_W-1:0] ray_z;
	logic [IDX_OUT_W-1:0]     column;
	logic [IDX_OUT_W-1:0]     row;
	logic                     last;

	modport source (output valid, output ray_x, output ray_y, output ray_z,
		output column, output row, output last, input ready);
	modport sink (input valid, input ray_x, input ray_y, input ray_z,
		input column, input row, input last, output ready);
endinterface

// ===== src/agrg_divider.sv =====
// ----------------------------------------------------------------------------
// Step divider
// Restoring divider, one quotient bit per cycle while step is high, for the angle steps.
// ----------------------------------------------------------------------------
module agrg_divider import agrg_pkg::*; #(
	parameter int DIVISOR_W = 11
) (
	input  logic                 clk,
	input  logic                 load,
	input  logic                 step,
	input  logic [AP_W-1:0]      dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic [AP_W-1:0]      quotient
);

	logic [DIVISOR_W-1:0] div_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [AP_W-1:0]      quot_q;
	logic [DIVISOR_W:0]   rem_sh;
	logic                 fits;

	assign rem_sh = {rem_q, quot_q[AP_W-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (load) begin
			div_q  <= divisor;
			rem_q  <= '0;
			quot_q <= dividend;
		end else if (step) begin
			// dividend bits shift out of the top as quotient bits shift in
			if (fits) begin
				rem_q <= DIVISOR_W'(rem_sh - {1'b0, div_q});
			end else begin
				rem_q <= rem_sh[DIVISOR_W-1:0];
			end
			quot_q <= {quot_q[AP_W-2:0], fits};
		end
	end

	assign quotient = quot_q;

endmodule

// ===== src/agrg_cordic.sv =====
// ----------------------------------------------------------------------------
// Sine/cosine unit
// Angle range reduction and rotation-mode CORDIC, one step per cycle while ctrl.op is OP_CORDIC.
// ----------------------------------------------------------------------------
module agrg_cordic import agrg_pkg::*; (
	input  logic                     clk,
	input  ctrl_t                    ctrl,
	input  logic [ANG_W-1:0]         angle,
	output logic                     z_gt_pi,
	output logic                     z_le_npi,
	output logic signed [TRIG_W-1:0] sin_val,
	output logic signed [TRIG_W-1:0] cos_val
);

	logic signed [CZ_W-1:0] z_q;
	logic signed [CX_W-1:0] x_q;
	logic signed [CX_W-1:0] y_q;
	logic                   neg_q;
	logic signed [CX_W-1:0] dx;
	logic signed [CX_W-1:0] dy;
	logic signed [CZ_W-1:0] atan_e;

	assign dx     = y_q >>> ctrl.iter;
	assign dy     = x_q >>> ctrl.iter;
	assign atan_e = CZ_W'(atan_q30(ctrl.iter));

	assign z_gt_pi  = z_q > PI_Q30;
	assign z_le_npi = z_q <= NEG_PI_Q30;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD_ZH, OP_LOAD_ZV: begin
				// Q3.13 to Q2.30
				z_q   <= $signed({angle[ANG_W-1], angle, 17'b0});
				neg_q <= 1'b0;
			end
			OP_RED_SUB: begin
				if (z_gt_pi) begin
					z_q <= z_q - TWO_PI_Q30;
				end
			end
			OP_RED_ADD: begin
				if (z_le_npi) begin
					z_q <= z_q + TWO_PI_Q30;
				end
			end
			OP_FOLD: begin
				// outside +-pi/2: rotate by pi, negate both results later
				if (z_q > HALF_PI_Q30) begin
					z_q   <= z_q - PI_Q30;
					neg_q <= 1'b1;
				end else if (z_q < NEG_HALF_PI) begin
					z_q   <= z_q + PI_Q30;
					neg_q <= 1'b1;
				end
				x_q <= CORDIC_GAIN;
				y_q <= '0;
			end
			OP_CORDIC: begin
				if (!z_q[CZ_W-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_e;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_e;
				end
			end
			default: begin
			end
		endcase
	end

	assign sin_val = TRIG_W'(neg_q ? -y_q : y_q);
	assign cos_val = TRIG_W'(neg_q ? -x_q : x_q);

endmodule

// ===== src/agrg_sequencer.sv =====
// ----------------------------------------------------------------------------
// Microcode sequencer
// Program counter, loop counter and jump logic over the control store.
// ----------------------------------------------------------------------------
`include "angular_grid_ray_generator_unit_defines.svh"

module agrg_sequencer import agrg_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	logic [PC_W-1:0]   pc_q;
	logic [ITER_W-1:0] iter_q;
	uword_t            uw;
	logic              iter_busy;
	logic              take_jump;

	assign uw = ucode_rom(pc_q);

	assign iter_busy = (uw.op == OP_DIV_STEP) ? (iter_q != ITER_W'(DIV_STEPS - 1))
		: (iter_q != ITER_W'(CORDIC_STEPS - 1));

	always_comb begin
		case (uw.cond)
			C_NEVER:      take_jump = 1'b0;
			C_ALWAYS:     take_jump = 1'b1;
			C_NO_REQ:     take_jump = !status.req_valid;
			C_NO_RESTART: take_jump = !status.restart;
			C_ITER_BUSY:  take_jump = iter_busy;
			C_Z_GT_PI:    take_jump = status.z_gt_pi;
			C_Z_LE_NPI:   take_jump = status.z_le_npi;
			C_OUT_FULL:   take_jump = status.out_full;
			default:      take_jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= PC_WAIT;
			iter_q <= '0;
		end else begin
			pc_q <= take_jump ? uw.target : pc_q + 1'b1;
			case (uw.op)
				OP_DIVH_INIT, OP_DIVH_STORE, OP_FOLD: iter_q <= '0;
				OP_DIV_STEP, OP_CORDIC:               iter_q <= iter_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	assign ctrl.op   = uw.op;
	assign ctrl.iter = iter_q;

	`AGRG_ASSERT_IMP(a_cordic_iter_range, clk, arst_n, uw.op == OP_CORDIC, iter_q < ITER_W'(CORDIC_STEPS))
	`AGRG_ASSERT_IMP(a_div_iter_range, clk, arst_n, uw.op == OP_DIV_STEP, iter_q < ITER_W'(DIV_STEPS))
	`AGRG_ASSERT_NXT(a_accept_advances, clk, arst_n, uw.op == OP_ACCEPT && status.req_valid, pc_q == PC_CHK_RST)

endmodule

// ===== src/angular_grid_ray_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Angular grid ray generator
// Each request returns the next unit ray (Q1.14) of a column-major scan grid
// over the configured apertures, computed by two passes, each with angle
// wrap-round, through the single shared CORDIC; a restart request, and the
// first one after reset, also runs the two step divisions (one quotient bit
// per cycle). The next request is taken once the result sits in the output
// register, which then waits for the ray side to take it.
// ----------------------------------------------------------------------------
`include "angular_grid_ray_generator_unit_defines.svh"

module angular_grid_ray_generator_unit import agrg_pkg::*; #(
	parameter int MAX_POINTS   = MAX_POINTS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	agrg_req_if.sink              req,
	agrg_ray_if.source            ray
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	// configuration
	logic [AP_W-1:0]      h_ap_q;
	logic [AP_W-1:0]      v_ap_q;
	logic [CFG_CNT_W-1:0] h_cnt_q;
	logic [CFG_CNT_W-1:0] v_cnt_q;

	// scan state
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] row_q;
	logic [ANG_W-1:0] h_ang_q;
	logic [ANG_W-1:0] v_ang_q;
	logic [AP_W-1:0]  h_step_q;
	logic [AP_W-1:0]  v_step_q;
	logic             started_q;
	logic             restart_q;

	// datapath
	logic signed [TRIG_W-1:0]   sa_q;
	logic signed [TRIG_W-1:0]   ca_q;
	logic signed [TRIG_W-1:0]   sb_q;
	logic signed [TRIG_W-1:0]   cb_q;
	logic signed [2*TRIG_W-1:0] prod_q;
	logic signed [COMP_W-1:0]   xres_q;

	// output register
	logic                     out_valid_q;
	logic signed [COMP_W-1:0] out_x_q;
	logic signed [COMP_W-1:0] out_y_q;
	logic signed [COMP_W-1:0] out_z_q;
	logic [IDX_OUT_W-1:0]     out_col_q;
	logic [IDX_OUT_W-1:0]     out_row_q;
	logic                     out_last_q;

	ctrl_t                    ctrl;
	status_t                  status;
	logic [CNT_W-1:0]         hc;
	logic [CNT_W-1:0]         vc;
	logic [CNT_W-1:0]         col_nx;
	logic [CNT_W-1:0]         row_nx;
	logic                     last_w;
	logic                     accept;
	logic                     emit;
	logic                     div_load;
	logic [AP_W-1:0]          div_dividend;
	logic [CNT_W-1:0]         div_divisor;
	logic [AP_W-1:0]          quotient;
	logic [ANG_W-1:0]         cordic_ang;
	logic                     z_gt_pi;
	logic                     z_le_npi;
	logic signed [TRIG_W-1:0] sin_val;
	logic signed [TRIG_W-1:0] cos_val;
	logic signed [TRIG_W-1:0] mul_a;
	logic signed [2*TRIG_W-1:0] mul_p;
	logic signed [2*TRIG_W-1:0] prod_rnd;
	logic signed [TRIG_W:0]     y_rnd;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c == '0) begin
			r = CNT_W'(1);
		end else if (int'(c) > MAX_POINTS) begin
			r = CNT_W'(MAX_POINTS);
		end else begin
			r = CNT_W'(c);
		end
		return r;
	endfunction

	// minus half the aperture, odd LSB dropped
	function automatic logic [ANG_W-1:0] start_angle(input logic [AP_W-1:0] ap);
		return ANG_W'(0) - ANG_W'(ap >> 1);
	endfunction

	function automatic logic signed [COMP_W-1:0] clamp_q14(input logic signed [17:0] v);
		logic signed [COMP_W-1:0] r;
		if (v > 18'sd16384) begin
			r = 16'sd16384;
		end else if (v < -18'sd16384) begin
			r = -16'sd16384;
		end else begin
			r = COMP_W'(v);
		end
		return r;
	endfunction

	assign hc = clamp_count(h_cnt_q);
	assign vc = clamp_count(v_cnt_q);

	assign col_nx = CNT_W'(col_q) + CNT_W'(1);
	assign row_nx = CNT_W'(row_q) + CNT_W'(1);
	assign last_w = (col_nx >= hc) && (row_nx >= vc);

	assign req.ready = (ctrl.op == OP_ACCEPT);
	assign accept    = req.valid && req.ready;
	assign emit      = (ctrl.op == OP_EMIT) && !status.out_full;

	assign status.req_valid = req.valid;
	assign status.restart   = restart_q;
	assign status.out_full  = out_valid_q && !ray.ready;
	assign status.z_gt_pi   = z_gt_pi;
	assign status.z_le_npi  = z_le_npi;

	agrg_sequencer #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// horizontal division is loaded first, vertical one as it stores
	assign div_load     = (ctrl.op == OP_DIVH_INIT) || (ctrl.op == OP_DIVH_STORE);
	assign div_dividend = (ctrl.op == OP_DIVH_INIT) ? h_ap_q : v_ap_q;
	assign div_divisor  = (ctrl.op == OP_DIVH_INIT) ? hc - CNT_W'(1) : vc - CNT_W'(1);

	agrg_divider #(
		.DIVISOR_W(CNT_W)
	) u_div (
		.clk      (clk),
		.load     (div_load),
		.step     (ctrl.op == OP_DIV_STEP),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient)
	);

	assign cordic_ang = (ctrl.op == OP_LOAD_ZV) ? v_ang_q : h_ang_q;

	agrg_cordic u_cordic (
		.clk      (clk),
		.ctrl     (ctrl),
		.angle    (cordic_ang),
		.z_gt_pi  (z_gt_pi),
		.z_le_npi (z_le_npi),
		.sin_val  (sin_val),
		.cos_val  (cos_val)
	);

	// one multiplier: cos(b)*sin(a), then cos(b)*cos(a)
	assign mul_a    = (ctrl.op == OP_MUL_Z) ? ca_q : sa_q;
	assign mul_p    = mul_a * cb_q;
	assign prod_rnd = prod_q + 64'sd35184372088832;
	assign y_rnd    = (TRIG_W + 1)'(sb_q) + 33'sd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_ap_q  <= H_APERTURE_RST;
			v_ap_q  <= V_APERTURE_RST;
			h_cnt_q <= H_COUNT_RST;
			v_cnt_q <= V_COUNT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_H_APERTURE: h_ap_q  <= cfg_data;
				REG_V_APERTURE: v_ap_q  <= cfg_data;
				REG_H_COUNT:    h_cnt_q <= cfg_data[CFG_CNT_W-1:0];
				REG_V_COUNT:    v_cnt_q <= cfg_data[CFG_CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			h_ang_q   <= '0;
			v_ang_q   <= '0;
			h_step_q  <= '0;
			v_step_q  <= '0;
			started_q <= 1'b0;
			restart_q <= 1'b0;
		end else begin
			if (accept) begin
				restart_q <= req.restart || !started_q;
			end
			case (ctrl.op)
				OP_DIVH_INIT: begin
					col_q     <= '0;
					row_q     <= '0;
					h_ang_q   <= start_angle(h_ap_q);
					v_ang_q   <= start_angle(v_ap_q);
					started_q <= 1'b1;
				end
				OP_DIVH_STORE: h_step_q <= (hc < CNT_W'(2)) ? '0 : quotient;
				OP_DIVV_STORE: v_step_q <= (vc < CNT_W'(2)) ? '0 : quotient;
				OP_EMIT: begin
					if (emit) begin
						// counts are read live: an index past its count ends the walk
						if (row_nx < vc) begin
							row_q   <= IDX_W'(row_nx);
							v_ang_q <= v_ang_q + ANG_W'(v_step_q);
						end else begin
							row_q   <= '0;
							v_ang_q <= start_angle(v_ap_q);
							if (col_nx < hc) begin
								col_q   <= IDX_W'(col_nx);
								h_ang_q <= h_ang_q + ANG_W'(h_step_q);
							end else begin
								col_q   <= '0;
								h_ang_q <= start_angle(h_ap_q);
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_STORE_H: begin
				sa_q <= sin_val;
				ca_q <= cos_val;
			end
			OP_STORE_V: begin
				sb_q <= sin_val;
				cb_q <= cos_val;
			end
			OP_MUL_X: prod_q <= mul_p;
			OP_MUL_Z: begin
				xres_q <= clamp_q14(prod_rnd[2*TRIG_W-1:46]);
				prod_q <= mul_p;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (ray.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q    <= xres_q;
			out_y_q    <= clamp_q14({y_rnd[TRIG_W], y_rnd[TRIG_W:16]});
			out_z_q    <= clamp_q14(prod_rnd[2*TRIG_W-1:46]);
			out_col_q  <= IDX_OUT_W'(col_q);
			out_row_q  <= IDX_OUT_W'(row_q);
			out_last_q <= last_w;
		end
	end

	assign ray.valid  = out_valid_q;
	assign ray.ray_x  = out_x_q;
	assign ray.ray_y  = out_y_q;
	assign ray.ray_z  = out_z_q;
	assign ray.column = out_col_q;
	assign ray.row    = out_row_q;
	assign ray.last   = out_last_q;

	`AGRG_ASSERT_NXT(a_valid_only_from_emit, clk, arst_n, !out_valid_q && ctrl.op != OP_EMIT, !out_valid_q)
	`AGRG_ASSERT_IMP(a_emit_after_start, clk, arst_n, ctrl.op == OP_EMIT, started_q)

endmodule
